>>> rtl/core/dwesm_pkg.sv
// Shared types and constants for the dual wheel encoder speed meter.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package dwesm_pkg;

  localparam int unsigned CIRC_W    = 20;  // circumference register width
  localparam int unsigned TMO_W     = 32;  // stall timeout register width
  localparam int unsigned CFG_W     = 32;  // config write data width
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned NOW_W     = 48;
  localparam int unsigned SCALED_W  = 40;  // circumference * 1e6 fits here

  localparam logic [19:0] MICRO_PER_SEC = 20'd1000000;

  localparam logic [CIRC_W-1:0] CIRC_RESET = 20'd100000;
  localparam logic [TMO_W-1:0]  TMO_RESET  = 32'd2000000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIRC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;

  // command codes
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // speed_updated codes
  localparam logic [1:0] UPD_NONE  = 2'd0;
  localparam logic [1:0] UPD_LEFT  = 2'd1;
  localparam logic [1:0] UPD_RIGHT = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic             wheel;
    logic             pin_level;
    logic [NOW_W-1:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] left_holes;
    logic [COUNT_W-1:0] right_holes;
    logic [SPEED_W-1:0] left_speed_umps;
    logic [SPEED_W-1:0] right_speed_umps;
    logic [1:0]         speed_updated;
    logic               left_stalled;
    logic               right_stalled;
  } out_word_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/dwesm_mul.sv
// Bit-serial multiplier: circumference times one million, MSB first.
// Depends on dwesm_pkg.
`default_nettype none

module dwesm_mul (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [dwesm_pkg::CIRC_W-1:0]   circ_i,
  output dwesm_pkg::unit_stat_t               stat_o,
  output logic [dwesm_pkg::SCALED_W-1:0]      prod_o
);

  localparam int unsigned CNT_W = $clog2(dwesm_pkg::CIRC_W + 1);

  logic [dwesm_pkg::CIRC_W-1:0]   sh_q, sh_d;
  logic [dwesm_pkg::SCALED_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;

  always_comb begin
    sh_d   = sh_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = circ_i;
      acc_d  = '0;
      cnt_d  = CNT_W'(dwesm_pkg::CIRC_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[dwesm_pkg::SCALED_W-2:0], 1'b0} +
              (sh_q[dwesm_pkg::CIRC_W-1] ?
               dwesm_pkg::SCALED_W'(dwesm_pkg::MICRO_PER_SEC) : '0);
      sh_d  = {sh_q[dwesm_pkg::CIRC_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/dwesm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on dwesm_pkg for the status struct.
`default_nettype none

module dwesm_div #(
  parameter int unsigned NW = 40,  // dividend and quotient width
  parameter int unsigned DW = 48   // divisor width
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NW-1:0]   dividend_i,
  input  wire logic [DW-1:0]   divisor_i,
  output dwesm_pkg::unit_stat_t stat_o,
  output logic [NW-1:0]        quo_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_q, quo_d;   // dividend shifts out, quotient shifts in
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DW:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/dual_wheel_encoder_speed_meter.sv
// Top level of the dual wheel encoder speed meter: control, wheel state, config.
// Depends on dwesm_pkg, dwesm_mul and dwesm_div.
//
//   channel   direction  handshake              word
//   in        input      in_valid_i/in_ready_o  dwesm_pkg::in_word_t
//   out       output     out_valid_o/out_ready_i dwesm_pkg::out_word_t
//   cfg       input      cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
// A rising edge with a nonzero interval passes from accept to result through
// the serial multiply by one million, then twice through the shared divider
// (by HOLES_PER_REV, then by the interval). Other words go straight to S_FIN.
// One word at a time; the next is taken once the result sits in the output
// register, even while that register waits on out_ready_i. Reset is async,
// active low, and clears all counts, times and speeds.
`default_nettype none

module dual_wheel_encoder_speed_meter #(
  parameter int unsigned HOLES_PER_REV = 20,
  parameter int unsigned TIME_BITS     = 48
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire dwesm_pkg::in_word_t              in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output dwesm_pkg::out_word_t                  out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [dwesm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dwesm_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned HOLES_W = $clog2(HOLES_PER_REV + 1);
  localparam int unsigned DW  = (TIME_BITS > HOLES_W) ? TIME_BITS : HOLES_W;
  localparam int unsigned NX  = (TIME_BITS > dwesm_pkg::NOW_W) ? TIME_BITS
                                                               : dwesm_pkg::NOW_W;
  localparam int unsigned CW  = (TIME_BITS > dwesm_pkg::TMO_W) ? TIME_BITS
                                                               : dwesm_pkg::TMO_W;
  localparam logic [DW-1:0] HOLES_DIV = DW'(HOLES_PER_REV);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIVH = 5'b00100,
    S_DIVI = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [dwesm_pkg::CIRC_W-1:0]  circ_q, circ_d;
  logic [dwesm_pkg::TMO_W-1:0]   tmo_q, tmo_d;

  logic [dwesm_pkg::COUNT_W-1:0] cnt_q  [2];
  logic [dwesm_pkg::COUNT_W-1:0] cnt_d  [2];
  logic [TIME_BITS-1:0]          last_q [2];
  logic [TIME_BITS-1:0]          last_d [2];
  logic [dwesm_pkg::SPEED_W-1:0] spd_q  [2];
  logic [dwesm_pkg::SPEED_W-1:0] spd_d  [2];

  logic                 wheel_q, wheel_d;
  logic [TIME_BITS-1:0] ivl_q, ivl_d;
  logic [1:0]           upd_q, upd_d;
  logic [1:0]           stl_q, stl_d;

  logic                 ov_q, ov_d;
  dwesm_pkg::out_word_t out_q, out_d;

  logic [NX-1:0]        now_x;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] ivl   [2];
  logic [1:0]           stall;
  logic [TIME_BITS-1:0] sel_ivl;

  logic                           mul_start;
  dwesm_pkg::unit_stat_t          mul_stat;
  logic [dwesm_pkg::SCALED_W-1:0] mul_prod;

  logic                           div_start;
  logic [dwesm_pkg::SCALED_W-1:0] div_dvd;
  logic [DW-1:0]                  div_dvs;
  dwesm_pkg::unit_stat_t          div_stat;
  logic [dwesm_pkg::SCALED_W-1:0] div_quo;
  logic [dwesm_pkg::SPEED_W-1:0]  div_sat;

  logic out_free;

  dwesm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .circ_i  (circ_q),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  dwesm_div #(
    .NW (dwesm_pkg::SCALED_W),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quo_o      (div_quo)
  );

  assign now_x   = NX'(in_data_i.now_us);
  assign now_t   = now_x[TIME_BITS-1:0];
  assign ivl[0]  = now_t - last_q[0];
  assign ivl[1]  = now_t - last_q[1];
  assign stall[0] = (CW'(ivl[0]) > CW'(tmo_q));
  assign stall[1] = (CW'(ivl[1]) > CW'(tmo_q));
  assign sel_ivl = ivl[in_data_i.wheel];

  assign div_sat = (|div_quo[dwesm_pkg::SCALED_W-1:dwesm_pkg::SPEED_W]) ?
                   dwesm_pkg::SPEED_MAX : div_quo[dwesm_pkg::SPEED_W-1:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !ov_q || out_ready_i;

  // config writes
  always_comb begin
    circ_d = circ_q;
    tmo_d  = tmo_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dwesm_pkg::REG_CIRC:    circ_d = cfg_wdata_i[dwesm_pkg::CIRC_W-1:0];
        dwesm_pkg::REG_TIMEOUT: tmo_d  = cfg_wdata_i[dwesm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    spd_d     = spd_q;
    wheel_d   = wheel_q;
    ivl_d     = ivl_q;
    upd_d     = upd_q;
    stl_d     = stl_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    div_dvd   = mul_prod;
    div_dvs   = HOLES_DIV;
    out_d     = out_q;
    ov_d      = ov_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FIN;
          upd_d   = dwesm_pkg::UPD_NONE;
          stl_d   = 2'b00;
          if (in_data_i.cmd == dwesm_pkg::CMD_CHECK) begin
            for (int w = 0; w < 2; w++) begin
              if (stall[w]) begin
                cnt_d[w]  = '0;
                last_d[w] = now_t;
                stl_d[w]  = 1'b1;
              end
            end
          end else if (in_data_i.pin_level) begin
            if (cnt_q[in_data_i.wheel] != dwesm_pkg::COUNT_MAX) begin
              cnt_d[in_data_i.wheel] = cnt_q[in_data_i.wheel] + 1'b1;
            end
            last_d[in_data_i.wheel] = now_t;
            upd_d   = in_data_i.wheel ? dwesm_pkg::UPD_RIGHT : dwesm_pkg::UPD_LEFT;
            wheel_d = in_data_i.wheel;
            ivl_d   = sel_ivl;
            if (sel_ivl == '0) begin
              spd_d[in_data_i.wheel] = dwesm_pkg::SPEED_MAX;
            end else begin
              mul_start = 1'b1;
              state_d   = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          div_start = 1'b1;
          div_dvd   = mul_prod;
          div_dvs   = HOLES_DIV;
          state_d   = S_DIVH;
        end
      end
      S_DIVH: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_dvd   = div_quo;
          div_dvs   = DW'(ivl_q);
          state_d   = S_DIVI;
        end
      end
      S_DIVI: begin
        if (div_stat.done) begin
          spd_d[wheel_q] = div_sat;
          state_d        = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_d.left_holes       = cnt_q[0];
          out_d.right_holes      = cnt_q[1];
          out_d.left_speed_umps  = spd_q[0];
          out_d.right_speed_umps = spd_q[1];
          out_d.speed_updated    = upd_q;
          out_d.left_stalled     = stl_q[0];
          out_d.right_stalled    = stl_q[1];
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      circ_q  <= dwesm_pkg::CIRC_RESET;
      tmo_q   <= dwesm_pkg::TMO_RESET;
      cnt_q   <= '{default: '0};
      last_q  <= '{default: '0};
      spd_q   <= '{default: '0};
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      circ_q  <= circ_d;
      tmo_q   <= tmo_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      spd_q   <= spd_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wheel_q <= wheel_d;
    ivl_q   <= ivl_d;
    upd_q   <= upd_d;
    stl_q   <= stl_d;
    out_q   <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/dwesm_sva.sv
// Port-level checks for the speed meter, bound to the top level.
// Depends on dwesm_pkg and dual_wheel_encoder_speed_meter.
`default_nettype none

module dwesm_sva (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire dwesm_pkg::out_word_t             out_data_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // one word in flight: input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_upd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.speed_updated == dwesm_pkg::UPD_NONE ||
                     out_data_o.speed_updated == dwesm_pkg::UPD_LEFT ||
                     out_data_o.speed_updated == dwesm_pkg::UPD_RIGHT))
    else $error("bad speed_updated code");

  // a stall clear only comes from a check, which never updates a speed
  a_stall_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.left_stalled || out_data_o.right_stalled) |->
      out_data_o.speed_updated == dwesm_pkg::UPD_NONE)
    else $error("stall flag with speed update");

  // a cleared left wheel reports a zero count
  a_stall_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.left_stalled |-> out_data_o.left_holes == '0)
    else $error("left stalled with nonzero count");

endmodule

bind dual_wheel_encoder_speed_meter dwesm_sva u_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
